// ===== rtl/core/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the command line tokenizer
// Character codes, parser mode codes and the result record.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam int CP_W = 21;
	localparam int MODE_W = 3;

	localparam logic [CP_W-1:0] CH_QUOTE = 21'h00022;
	localparam logic [CP_W-1:0] CH_SPACE = 21'h00020;
	localparam logic [CP_W-1:0] CH_BSLASH = 21'h0005C;

	// parser modes
	localparam logic [MODE_W-1:0] MODE_UNQ = 3'd0;
	localparam logic [MODE_W-1:0] MODE_QUO = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SPC = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ESC = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QESC = 3'd4;

	// input item kinds
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOL = 1'b1;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef struct packed {
		logic kind;
		logic [CP_W-1:0] ch;
		logic last;
	} res_t;

endpackage

// ===== rtl/core/clt_decode.sv =====
// ----------------------------------------------------------------------------
// clt_decode: tokenizer step logic
// From the current mode and one input item, works out up to two results
// and the next mode and argument flag.
// ----------------------------------------------------------------------------
module clt_decode
	import clt_pkg::*;
(
	input  logic [MODE_W-1:0] mode,
	input  logic nonempty,
	input  logic op,
	input  logic [CP_W-1:0] cp,
	output logic [1:0] res_n,
	output res_t res0,
	output res_t res1,
	output logic [MODE_W-1:0] mode_nxt,
	output logic nonempty_nxt
);

	logic is_quote;
	logic is_space;
	logic is_bslash;
	res_t r_end;
	res_t r_char;
	res_t r_bsl;

	assign is_quote = (cp == CH_QUOTE);
	assign is_space = (cp == CH_SPACE);
	assign is_bslash = (cp == CH_BSLASH);

	always_comb begin
		r_end = '{kind: KIND_END, ch: '0, last: 1'b0};
		r_char = '{kind: KIND_CHAR, ch: cp, last: 1'b0};
		r_bsl = '{kind: KIND_CHAR, ch: CH_BSLASH, last: 1'b0};

		res_n = 2'd0;
		res0 = r_char;
		res1 = r_char;
		mode_nxt = mode;
		nonempty_nxt = nonempty;

		if (op == OP_EOL) begin
			if (nonempty) begin
				res_n = 2'd1;
				res0 = r_end;
			end
			mode_nxt = MODE_UNQ;
			nonempty_nxt = 1'b0;
		end else begin
			case (mode)
				MODE_QUO: begin
					if (is_quote) begin
						res_n = 2'd1;
						res0 = r_end;
						nonempty_nxt = 1'b0;
						mode_nxt = MODE_UNQ;
					end else if (is_bslash) begin
						mode_nxt = MODE_QESC;
					end else begin
						res_n = 2'd1;
						nonempty_nxt = 1'b1;
					end
				end
				MODE_SPC: begin
					if (!is_space) begin
						// pending separator goes out ahead of the character
						if (nonempty) begin
							res0 = r_end;
							nonempty_nxt = 1'b0;
						end
						if (is_quote) begin
							mode_nxt = MODE_QUO;
							res_n = {1'b0, nonempty};
						end else if (is_bslash) begin
							mode_nxt = MODE_ESC;
							res_n = {1'b0, nonempty};
						end else begin
							mode_nxt = MODE_UNQ;
							nonempty_nxt = 1'b1;
							res_n = nonempty ? 2'd2 : 2'd1;
						end
					end
				end
				MODE_ESC, MODE_QESC: begin
					// backslash is only swallowed in front of a quote
					if (is_quote) begin
						res_n = 2'd1;
					end else begin
						res_n = 2'd2;
						res0 = r_bsl;
					end
					nonempty_nxt = 1'b1;
					mode_nxt = (mode == MODE_QESC) ? MODE_QUO : MODE_UNQ;
				end
				default: begin
					if (is_quote) begin
						mode_nxt = MODE_QUO;
					end else if (is_space) begin
						mode_nxt = MODE_SPC;
					end else if (is_bslash) begin
						mode_nxt = MODE_ESC;
					end else begin
						res_n = 2'd1;
						nonempty_nxt = 1'b1;
						mode_nxt = MODE_UNQ;
					end
				end
			endcase
		end

		res0.last = (res_n == 2'd1);
		res1.last = 1'b1;
	end

endmodule

// ===== rtl/core/clt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// clt_out_fifo: two-entry result queue
// Takes zero, one or two results a cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
module clt_out_fifo
	import clt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [1:0] push_n,
	input  res_t push0,
	input  res_t push1,
	output logic [1:0] free,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	res_t buf_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic pop;

	assign out_valid = (count_q != 2'd0);
	assign pop = out_valid && out_ready;
	assign out_res = buf_q[rd_ptr_q];
	// room left once this cycle's pop is taken into account
	assign free = 2'd2 - count_q + {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q ^ push_n[0];
			rd_ptr_q <= rd_ptr_q ^ pop;
			count_q <= count_q + push_n - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			buf_q[wr_ptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			buf_q[~wr_ptr_q] <= push1;
		end
	end

endmodule

// ===== rtl/core/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer: splits a code point stream into arguments
// Input register, step logic and a two-entry result queue.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per character: s_tuser is the op (0 character,
//   1 end of line), s_tdata[20:0] the code point.
//   m_* carries results: m_tuser 0 = argument character in m_tdata[20:0],
//   1 = end of argument; m_tlast marks the last result of an input request.
// Path: a request is held in the input register, decoded by the step logic
//   and written into the result queue, which drives m_tvalid.
// Throughput: one request per cycle while the queue has room; a request with
//   two results (a kept backslash, or an end mark followed by a character) is
//   handed out one result at a time by the single result port of the queue.
// Reset: arst_n clears the parser to unquoted mode with an empty argument and
//   empties the input register and the result queue.
// Stalls: when m_tready is low the queue holds up to two results; the input
//   register still takes a request and s_tready drops only when that request
//   cannot be placed in the queue.
// ----------------------------------------------------------------------------
module command_line_tokenizer
	import clt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
	input  logic s_tuser,          // [0] op
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,   // [20:0] char_out, [23:21] zero
	output logic m_tuser,          // [0] kind
	output logic m_tlast
);

	logic item_valid_s1;
	logic op_s1;
	logic [CP_W-1:0] cp_s1;
	logic [MODE_W-1:0] mode_q;
	logic nonempty_q;

	logic [1:0] res_n;
	res_t res0;
	res_t res1;
	logic [MODE_W-1:0] mode_nxt;
	logic nonempty_nxt;
	logic [1:0] free;
	logic consume;
	logic [1:0] push_n;
	res_t out_res;

	clt_decode u_decode (
		.mode(mode_q),
		.nonempty(nonempty_q),
		.op(op_s1),
		.cp(cp_s1),
		.res_n(res_n),
		.res0(res0),
		.res1(res1),
		.mode_nxt(mode_nxt),
		.nonempty_nxt(nonempty_nxt)
	);

	assign consume = item_valid_s1 && (res_n <= free);
	assign push_n = consume ? res_n : 2'd0;
	assign s_tready = !item_valid_s1 || consume;

	clt_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.push0(res0),
		.push1(res1),
		.free(free),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(out_res)
	);

	assign m_tdata = {3'b000, out_res.ch};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			mode_q <= MODE_UNQ;
			nonempty_q <= 1'b0;
		end else begin
			if (s_tready) begin
				item_valid_s1 <= s_tvalid;
			end
			if (consume) begin
				mode_q <= mode_nxt;
				nonempty_q <= nonempty_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= s_tuser;
			cp_s1 <= s_tdata[CP_W-1:0];
		end
	end

endmodule
